@@ hw/rtl/cpu8_pkg.sv @@
// Shared operation codes, decoded transaction type and constants for the 8-bit ALU core.
package cpu8_pkg;

	// Operation codes as they arrive on the mode field
	localparam logic [4:0] MODE_ADC    = 5'd0;
	localparam logic [4:0] MODE_SBC    = 5'd1;
	localparam logic [4:0] MODE_ORA    = 5'd2;
	localparam logic [4:0] MODE_AND    = 5'd3;
	localparam logic [4:0] MODE_EOR    = 5'd4;
	localparam logic [4:0] MODE_ASL    = 5'd5;
	localparam logic [4:0] MODE_LSR    = 5'd6;
	localparam logic [4:0] MODE_ROL    = 5'd7;
	localparam logic [4:0] MODE_ROR    = 5'd8;
	localparam logic [4:0] MODE_BIT    = 5'd9;
	localparam logic [4:0] MODE_BITIMM = 5'd10;
	localparam logic [4:0] MODE_TRB    = 5'd11;
	localparam logic [4:0] MODE_TSB    = 5'd12;
	localparam logic [4:0] MODE_CMP    = 5'd13;
	localparam logic [4:0] MODE_CPXY   = 5'd14;
	localparam logic [4:0] MODE_INC    = 5'd15;
	localparam logic [4:0] MODE_DEC    = 5'd16;
	localparam logic [4:0] MODE_SEC    = 5'd17;
	localparam logic [4:0] MODE_CLC    = 5'd18;
	localparam logic [4:0] MODE_SEI    = 5'd19;
	localparam logic [4:0] MODE_CLI    = 5'd20;
	localparam logic [4:0] MODE_SED    = 5'd21;
	localparam logic [4:0] MODE_CLD    = 5'd22;
	localparam logic [4:0] MODE_CLV    = 5'd23;
	localparam logic [4:0] MODE_LDA    = 5'd24;

	// Decimal adjust and BCD constants
	localparam logic [7:0] BCD_NINES   = 8'h99;
	localparam logic [9:0] BCD_ADJ_HI  = 10'h060;
	localparam logic [9:0] BCD_ADJ_LO  = 10'h006;
	localparam logic [4:0] BCD_DIGIT_MAX = 5'd9;
	localparam logic [9:0] BYTE_MAX    = 10'h0FF;
	localparam logic [9:0] BCD_MAX     = 10'h099;

	// Queue depth between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Decoded operation classes
	typedef enum logic [4:0] {
		OP_ADC, OP_SBC, OP_ORA, OP_AND, OP_EOR,
		OP_ASL, OP_LSR, OP_ROL, OP_ROR,
		OP_BIT, OP_BITIMM, OP_TRB, OP_TSB,
		OP_CMP, OP_CPXY, OP_INC, OP_DEC,
		OP_SEC, OP_CLC, OP_SEI, OP_CLI, OP_SED, OP_CLD, OP_CLV,
		OP_LDA, OP_NOP
	} op_t;

	// One classified transaction on its way to the back end
	typedef struct packed {
		op_t        op;
		logic [7:0] operand;
		logic [7:0] index_value;
		logic       on_acc;
	} item_t;

endpackage

@@ hw/rtl/cpu8_front.sv @@
// Front end: accept input transactions, classify the operation and hand them to the queue.
module cpu8_front
	import cpu8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] mode,
	input  logic [7:0] operand,
	input  logic       on_accumulator,
	input  logic [7:0] index_value,
	output logic       push_valid,
	input  logic       push_ready,
	output item_t      push_item
);

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;

	// Classify the mode field
	always_comb begin
		unique case (mode)
			MODE_ADC:    op_dec = OP_ADC;
			MODE_SBC:    op_dec = OP_SBC;
			MODE_ORA:    op_dec = OP_ORA;
			MODE_AND:    op_dec = OP_AND;
			MODE_EOR:    op_dec = OP_EOR;
			MODE_ASL:    op_dec = OP_ASL;
			MODE_LSR:    op_dec = OP_LSR;
			MODE_ROL:    op_dec = OP_ROL;
			MODE_ROR:    op_dec = OP_ROR;
			MODE_BIT:    op_dec = OP_BIT;
			MODE_BITIMM: op_dec = OP_BITIMM;
			MODE_TRB:    op_dec = OP_TRB;
			MODE_TSB:    op_dec = OP_TSB;
			MODE_CMP:    op_dec = OP_CMP;
			MODE_CPXY:   op_dec = OP_CPXY;
			MODE_INC:    op_dec = OP_INC;
			MODE_DEC:    op_dec = OP_DEC;
			MODE_SEC:    op_dec = OP_SEC;
			MODE_CLC:    op_dec = OP_CLC;
			MODE_SEI:    op_dec = OP_SEI;
			MODE_CLI:    op_dec = OP_CLI;
			MODE_SED:    op_dec = OP_SED;
			MODE_CLD:    op_dec = OP_CLD;
			MODE_CLV:    op_dec = OP_CLV;
			MODE_LDA:    op_dec = OP_LDA;
			default:     op_dec = OP_NOP;
		endcase
	end

	// Take a new transaction whenever the stage is empty or drains this cycle
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the classified payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op          <= op_dec;
			item_s1.operand     <= operand;
			item_s1.index_value <= index_value;
			item_s1.on_acc      <= on_accumulator;
		end
	end

endmodule

@@ hw/rtl/cpu8_queue.sv @@
// Short register queue that decouples the front end from the execute back end.
module cpu8_queue
	import cpu8_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/cpu8_back.sv @@
// Back end: one op per cycle on accumulator and flags, if not stalled; result registered.
module cpu8_back
	import cpu8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  item_t      pop_item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_value,
	output logic       write_back,
	output logic [7:0] accumulator_out,
	output logic [7:0] status_out
);

	// Architectural state
	logic [7:0] acc_q;
	logic       c_q, z_q, n_q, v_q, d_q, i_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] result_value_q;
	logic       write_back_q;
	logic [7:0] acc_out_q;
	logic [7:0] status_q;

	// Next-state values
	logic [7:0] acc_n;
	logic       c_n, z_n, n_n, v_n, d_n, i_n;
	logic [7:0] res_n;
	logic       wb_n;

	// Datapath intermediates
	logic [7:0] opd;
	logic [7:0] add_b;
	logic [4:0] lo_sum;
	logic [9:0] sum_bin;
	logic [9:0] sum_lo;
	logic [9:0] sum_fin;
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;
	logic [7:0] sh_src;
	logic [7:0] sh_val;
	logic       sh_cout;
	logic       exec;

	assign opd       = pop_item.operand;
	assign pop_ready = !out_valid_q || out_ready;
	assign exec      = pop_valid && pop_ready;

	// Adder with optional decimal adjust; subtract feeds the nines or ones complement
	always_comb begin
		if (pop_item.op == OP_SBC) begin
			add_b = d_q ? (BCD_NINES - opd) : ~opd;
		end else begin
			add_b = opd;
		end
		lo_sum  = {1'b0, acc_q[3:0]} + {1'b0, add_b[3:0]} + {4'd0, c_q};
		sum_bin = {2'b00, acc_q} + {2'b00, add_b} + {9'd0, c_q};
		sum_lo  = (d_q && (lo_sum > BCD_DIGIT_MAX)) ? (sum_bin + BCD_ADJ_LO) : sum_bin;
		sum_fin = (d_q && (sum_lo > BCD_MAX)) ? (sum_lo + BCD_ADJ_HI) : sum_lo;
	end

	// Compare against accumulator or index register
	always_comb begin
		cmp_reg  = (pop_item.op == OP_CPXY) ? pop_item.index_value : acc_q;
		cmp_diff = {1'b0, cmp_reg} - {1'b0, opd};
	end

	// Shift and rotate on accumulator or operand
	always_comb begin
		sh_src = pop_item.on_acc ? acc_q : opd;
		case (pop_item.op)
			OP_ASL: begin
				sh_val  = {sh_src[6:0], 1'b0};
				sh_cout = sh_src[7];
			end
			OP_ROL: begin
				sh_val  = {sh_src[6:0], c_q};
				sh_cout = sh_src[7];
			end
			OP_ROR: begin
				sh_val  = {c_q, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
			default: begin
				sh_val  = {1'b0, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
		endcase
	end

	// Select next state and result per operation
	always_comb begin
		acc_n = acc_q;
		c_n   = c_q;
		z_n   = z_q;
		n_n   = n_q;
		v_n   = v_q;
		d_n   = d_q;
		i_n   = i_q;
		res_n = 8'h00;
		wb_n  = 1'b0;
		unique case (pop_item.op)
			OP_ADC, OP_SBC: begin
				acc_n = sum_fin[7:0];
				c_n   = (sum_fin > BYTE_MAX);
				v_n   = (acc_q[7] ^ sum_fin[7]) & (add_b[7] ^ sum_fin[7]);
				z_n   = (sum_fin[7:0] == 8'h00);
				n_n   = sum_fin[7];
			end
			OP_ORA, OP_AND, OP_EOR, OP_LDA: begin
				case (pop_item.op)
					OP_ORA:  acc_n = acc_q | opd;
					OP_AND:  acc_n = acc_q & opd;
					OP_EOR:  acc_n = acc_q ^ opd;
					default: acc_n = opd;
				endcase
				z_n = (acc_n == 8'h00);
				n_n = acc_n[7];
			end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				c_n = sh_cout;
				z_n = (sh_val == 8'h00);
				n_n = sh_val[7];
				if (pop_item.on_acc) begin
					acc_n = sh_val;
				end else begin
					res_n = sh_val;
					wb_n  = 1'b1;
				end
			end
			OP_BIT: begin
				z_n = ((opd & acc_q) == 8'h00);
				n_n = opd[7];
				v_n = opd[6];
			end
			OP_BITIMM: begin
				z_n = ((opd & acc_q) == 8'h00);
			end
			OP_TRB: begin
				z_n   = ((opd & acc_q) == 8'h00);
				res_n = opd & ~acc_q;
				wb_n  = 1'b1;
			end
			OP_TSB: begin
				z_n   = ((opd & acc_q) == 8'h00);
				res_n = opd | acc_q;
				wb_n  = 1'b1;
			end
			OP_CMP, OP_CPXY: begin
				z_n = (cmp_reg == opd);
				c_n = !cmp_diff[8];
				n_n = cmp_diff[7];
			end
			OP_INC, OP_DEC: begin
				res_n = (pop_item.op == OP_INC) ? (opd + 8'd1) : (opd - 8'd1);
				wb_n  = 1'b1;
				z_n   = (res_n == 8'h00);
				n_n   = res_n[7];
			end
			OP_SEC: c_n = 1'b1;
			OP_CLC: c_n = 1'b0;
			OP_SEI: i_n = 1'b1;
			OP_CLI: i_n = 1'b0;
			OP_SED: d_n = 1'b1;
			OP_CLD: d_n = 1'b0;
			OP_CLV: v_n = 1'b0;
			default: begin
				// unused modes leave state alone
			end
		endcase
	end

	// Commit state and show the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 8'h00;
			c_q         <= 1'b0;
			z_q         <= 1'b0;
			n_q         <= 1'b0;
			v_q         <= 1'b0;
			d_q         <= 1'b0;
			i_q         <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				acc_q <= acc_n;
				c_q   <= c_n;
				z_q   <= z_n;
				n_q   <= n_n;
				v_q   <= v_n;
				d_q   <= d_n;
				i_q   <= i_n;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			result_value_q <= res_n;
			write_back_q   <= wb_n;
			acc_out_q      <= acc_n;
			status_q       <= {n_n, v_n, 1'b1, 1'b0, d_n, i_n, z_n, c_n};
		end
	end

	assign out_valid       = out_valid_q;
	assign result_value    = result_value_q;
	assign write_back      = write_back_q;
	assign accumulator_out = acc_out_q;
	assign status_out      = status_q;

endmodule

@@ hw/rtl/cpu8_alu_with_flags_core.sv @@
// Path: front stage register, queue entry, output register. Throughput: one
// transaction per cycle while out_ready is high; the execute unit closes the flag
// and accumulator loop, and the two-entry queue absorbs stalls.
// Reset (arst_n low, asynchronous): accumulator and C, Z, N, V, D cleared,
// I set, queue and output emptied.
module cpu8_alu_with_flags_core
	import cpu8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] mode,
	input  logic [7:0] operand,
	input  logic       on_accumulator,
	input  logic [7:0] index_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_value,
	output logic       write_back,
	output logic [7:0] accumulator_out,
	output logic [7:0] status_out
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	// Accept and classify
	cpu8_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.operand        (operand),
		.on_accumulator (on_accumulator),
		.index_value    (index_value),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	// Decouple front and back
	cpu8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Execute and register results
	cpu8_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_value    (result_value),
		.write_back      (write_back),
		.accumulator_out (accumulator_out),
		.status_out      (status_out)
	);

endmodule
